// File: src/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types, codes and constants for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

  localparam int KEY_W          = 32;
  localparam int MODE_W         = 2;
  localparam int POS_W          = 6;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 7;
  localparam int HEAP_DEPTH_DEF = 64;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT  = 2'd0,
    MODE_EXTRACT = 2'd1,
    MODE_DELETE  = 2'd2,
    MODE_PEEK    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_RM,
    ST_TAKE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FINISH
  } state_t;

  // Signed key comparison, the compare unit of every sift step.
  function automatic logic key_greater(input logic signed [KEY_W-1:0] a,
                                       input logic signed [KEY_W-1:0] b);
    return a > b;
  endfunction

endpackage

`default_nettype wire

// File: src/bmhq_if.sv
// ----------------------------------------------------------------------------
// bmhq_if
// Request and response channels of the heap queue, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmhq_req_if;
  logic                                valid;
  logic                                ready;
  logic [bmhq_pkg::MODE_W-1:0]         mode;
  logic signed [bmhq_pkg::KEY_W-1:0]   key_in;
  logic [bmhq_pkg::POS_W-1:0]          position;

  modport source (output valid, mode, key_in, position, input ready);
  modport sink   (input valid, mode, key_in, position, output ready);
endinterface

interface bmhq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [bmhq_pkg::STATUS_W-1:0]       status;
  logic signed [bmhq_pkg::KEY_W-1:0]   taken_key;
  logic signed [bmhq_pkg::KEY_W-1:0]   top_key;
  logic                                top_valid;
  logic [bmhq_pkg::COUNT_W-1:0]        entry_count;

  modport source (output valid, status, taken_key, top_key, top_valid, entry_count,
                  input ready);
  modport sink   (input valid, status, taken_key, top_key, top_valid, entry_count,
                  output ready);
endinterface

`default_nettype wire

// File: src/bmhq_mem.sv
// ----------------------------------------------------------------------------
// bmhq_mem
// Heap entry store: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_mem #(
  parameter int DEPTH = bmhq_pkg::HEAP_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [AW-1:0]                     waddr,
  input  wire logic signed [bmhq_pkg::KEY_W-1:0] wdata,
  input  wire logic [AW-1:0]                     raddr_a,
  input  wire logic [AW-1:0]                     raddr_b,
  output logic signed [bmhq_pkg::KEY_W-1:0]      rdata_a,
  output logic signed [bmhq_pkg::KEY_W-1:0]      rdata_b
);

  logic signed [bmhq_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: src/binary_max_heap_queue_top.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top
// Max-heap priority queue of signed keys: insert, extract, delete, peek.
// ----------------------------------------------------------------------------
// Peek and error items go straight from accept to the finish state, which loads
// the result register; insert, extract and delete first sift the heap in the store.
// Each heap level is a read of the store, then a compare and a write. One item
// is worked on at a time; the next is accepted as soon as the sequencer is
// idle, even while the last result waits in its register.
// Synchronous reset empties the heap; store contents are not cleared.
`default_nettype none

module binary_max_heap_queue_top #(
  parameter int HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  bmhq_req_if.sink    req,
  bmhq_rsp_if.source  rsp
);

  localparam int KW  = bmhq_pkg::KEY_W;
  localparam int IW  = $clog2(HEAP_DEPTH);
  localparam int CW  = $clog2(HEAP_DEPTH + 1);
  localparam int PW  = (CW > bmhq_pkg::POS_W) ? CW : bmhq_pkg::POS_W;
  localparam int XW  = IW + 2;

  bmhq_pkg::state_t  state, state_next;
  bmhq_pkg::status_t status_r, status_next;

  logic [CW-1:0]        cnt, cnt_next;
  logic [IW-1:0]        idx, idx_next;
  logic signed [KW-1:0] cur, cur_next;
  logic signed [KW-1:0] root_key, root_next;
  logic signed [KW-1:0] taken, taken_next;
  logic                 dn_alt, dn_alt_next;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr, raddr_a, raddr_b;
  logic signed [KW-1:0] mem_wdata, rdata_a, rdata_b;

  logic                 rsp_valid;
  logic                 out_load;

  logic [IW-1:0]        parent_idx;
  logic [XW-1:0]        lchild, rchild, cnt_ext;
  logic                 l_ok, r_ok;
  logic [CW-1:0]        cnt_dec;
  logic [PW-1:0]        pos_ext, cnt_pos;
  logic                 gl, gr_c, gr_l, take_r;
  logic [CW+6:0]        cnt_wide;

  bmhq_mem #(.DEPTH(HEAP_DEPTH)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign parent_idx = (idx - IW'(1)) >> 1;
  assign lchild     = (XW'(idx) << 1) + XW'(1);
  assign rchild     = lchild + XW'(1);
  assign cnt_ext    = XW'(cnt);
  assign l_ok       = lchild < cnt_ext;
  assign r_ok       = rchild < cnt_ext;
  assign cnt_dec    = cnt - CW'(1);
  assign pos_ext    = PW'(req.position);
  assign cnt_pos    = PW'(cnt);
  assign cnt_wide   = (CW + 7)'(cnt);

  // Sift-down choice: the right child wins only when strictly larger than
  // whichever of the current key and the left child is ahead so far.
  assign gl     = bmhq_pkg::key_greater(rdata_a, cur);
  assign gr_c   = bmhq_pkg::key_greater(rdata_b, cur);
  assign gr_l   = bmhq_pkg::key_greater(rdata_b, rdata_a);
  assign take_r = r_ok && (gl ? gr_l : gr_c);

  assign req.ready = (state == bmhq_pkg::ST_IDLE);
  assign rsp.valid = rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmhq_pkg::ST_IDLE;
      cnt       <= '0;
      dn_alt    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      dn_alt <= dn_alt_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    cur      <= cur_next;
    root_key <= root_next;
    taken    <= taken_next;
    status_r <= status_next;
    if (out_load) begin
      rsp.status      <= status_r;
      rsp.taken_key   <= taken;
      rsp.top_key     <= (cnt != '0) ? root_key : '0;
      rsp.top_valid   <= (cnt != '0);
      rsp.entry_count <= cnt_wide[bmhq_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    state_next  = state;
    status_next = status_r;
    cnt_next    = cnt;
    idx_next    = idx;
    cur_next    = cur;
    taken_next  = taken;
    dn_alt_next = dn_alt;
    mem_we      = 1'b0;
    mem_waddr   = idx;
    mem_wdata   = cur;
    raddr_a     = idx;
    raddr_b     = idx;
    out_load    = 1'b0;

    unique case (state)
      bmhq_pkg::ST_IDLE: begin
        if (req.valid) begin
          status_next = bmhq_pkg::STATUS_OK;
          taken_next  = '0;
          dn_alt_next = 1'b0;
          state_next  = bmhq_pkg::ST_FINISH;
          unique case (bmhq_pkg::mode_t'(req.mode))
            bmhq_pkg::MODE_INSERT: begin
              if (cnt == CW'(HEAP_DEPTH)) begin
                status_next = bmhq_pkg::STATUS_FULL;
              end else begin
                cur_next   = req.key_in;
                idx_next   = cnt[IW-1:0];
                cnt_next   = cnt + CW'(1);
                state_next = bmhq_pkg::ST_UP_RD;
              end
            end
            bmhq_pkg::MODE_EXTRACT: begin
              if (cnt == '0) begin
                status_next = bmhq_pkg::STATUS_EMPTY;
              end else begin
                idx_next   = '0;
                state_next = bmhq_pkg::ST_RD_RM;
              end
            end
            bmhq_pkg::MODE_DELETE: begin
              if (cnt == '0) begin
                status_next = bmhq_pkg::STATUS_EMPTY;
              end else if (pos_ext >= cnt_pos) begin
                status_next = bmhq_pkg::STATUS_BAD_INDEX;
              end else begin
                idx_next   = pos_ext[IW-1:0];
                state_next = bmhq_pkg::ST_RD_RM;
              end
            end
            bmhq_pkg::MODE_PEEK: begin
              if (cnt == '0) begin
                status_next = bmhq_pkg::STATUS_EMPTY;
              end else begin
                taken_next = root_key;
              end
            end
            default: begin
              status_next = bmhq_pkg::STATUS_OK;
            end
          endcase
        end
      end

      bmhq_pkg::ST_RD_RM: begin
        raddr_a    = idx;
        raddr_b    = cnt_dec[IW-1:0];
        state_next = bmhq_pkg::ST_TAKE;
      end

      bmhq_pkg::ST_TAKE: begin
        taken_next = rdata_a;
        cur_next   = rdata_b;
        cnt_next   = cnt_dec;
        if (CW'(idx) == cnt_dec) begin
          state_next = bmhq_pkg::ST_FINISH;
        end else if (idx == '0) begin
          state_next = bmhq_pkg::ST_DN_RD;
        end else begin
          // A key moved into a hole may belong above it: try one step up first.
          dn_alt_next = 1'b1;
          state_next  = bmhq_pkg::ST_UP_RD;
        end
      end

      bmhq_pkg::ST_UP_RD: begin
        if (idx == '0) begin
          mem_we     = 1'b1;
          state_next = bmhq_pkg::ST_FINISH;
        end else begin
          raddr_a    = parent_idx;
          state_next = bmhq_pkg::ST_UP_CMP;
        end
      end

      bmhq_pkg::ST_UP_CMP: begin
        if (bmhq_pkg::key_greater(cur, rdata_a)) begin
          mem_we      = 1'b1;
          mem_wdata   = rdata_a;
          idx_next    = parent_idx;
          dn_alt_next = 1'b0;
          state_next  = bmhq_pkg::ST_UP_RD;
        end else if (dn_alt) begin
          dn_alt_next = 1'b0;
          state_next  = bmhq_pkg::ST_DN_RD;
        end else begin
          mem_we     = 1'b1;
          state_next = bmhq_pkg::ST_FINISH;
        end
      end

      bmhq_pkg::ST_DN_RD: begin
        if (!l_ok) begin
          mem_we     = 1'b1;
          state_next = bmhq_pkg::ST_FINISH;
        end else begin
          raddr_a    = lchild[IW-1:0];
          raddr_b    = rchild[IW-1:0];
          state_next = bmhq_pkg::ST_DN_CMP;
        end
      end

      bmhq_pkg::ST_DN_CMP: begin
        mem_we = 1'b1;
        if (take_r) begin
          mem_wdata  = rdata_b;
          idx_next   = rchild[IW-1:0];
          state_next = bmhq_pkg::ST_DN_RD;
        end else if (gl) begin
          mem_wdata  = rdata_a;
          idx_next   = lchild[IW-1:0];
          state_next = bmhq_pkg::ST_DN_RD;
        end else begin
          state_next = bmhq_pkg::ST_FINISH;
        end
      end

      bmhq_pkg::ST_FINISH: begin
        if (!rsp_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = bmhq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = bmhq_pkg::ST_IDLE;
      end
    endcase
  end

  // Position 0 of the store is mirrored so that the maximum is always at hand.
  assign root_next = (mem_we && mem_waddr == '0) ? mem_wdata : root_key;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(HEAP_DEPTH))
    else $error("entry count above heap depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state != bmhq_pkg::ST_IDLE)
    else $error("accepted item did not start the sequencer");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != bmhq_pkg::ST_IDLE && state != bmhq_pkg::ST_FINISH))
    else $error("store written outside an operation");

  a_error_no_key: assert property (@(posedge clk) disable iff (rst)
    (out_load && status_r != bmhq_pkg::STATUS_OK) |-> taken == '0)
    else $error("failed operation reports a taken key");

endmodule

`default_nettype wire
